/* rtl/core/tsd_pkg.sv */
// shared types and constants for the streaming tga decoder
package tsd_pkg;

    localparam logic [1:0] KIND_RUN  = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [1:0] FMT_RGBA8  = 2'd0;
    localparam logic [1:0] FMT_GRAY8  = 2'd1;
    localparam logic [1:0] FMT_GRAY16 = 2'd2;

    localparam logic [7:0] IMG_TRUE     = 8'd2;
    localparam logic [7:0] IMG_GRAY     = 8'd3;
    localparam logic [7:0] IMG_TRUE_RLE = 8'd10;
    localparam logic [7:0] IMG_GRAY_RLE = 8'd11;

    localparam logic [7:0] CMAP_PRESENT = 8'd1;
    localparam logic [4:0] HDR_LAST     = 5'd17;
    localparam logic [4:0] HDR_DEPTH    = 5'd16;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] RUN_MASK     = 8'h7F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_IDSKIP  = 6'b000010,
        PH_MAPSKIP = 6'b000100,
        PH_DATA    = 6'b001000,
        PH_DONE    = 6'b010000,
        PH_FAIL    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  run_count;
        logic [1:0]  pixel_format;
        logic [7:0]  red_or_gray;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } result_t;

    typedef struct packed {
        logic run;
        logic stat;
        logic stat_ok;
    } push_t;

endpackage

/* rtl/core/tga_image_stream_decoder_unit.sv */
// top level of the streaming tga image decoder
// A tga file enters one byte per request on the item channel, with
// end_of_file high on its last byte. Requests leave on the result channel:
// one pixel run for each completed pixel value, then one status after the
// last byte. Both channels use valid/stall; a request moves when valid is
// high and stall is low.
// A byte is taken every cycle while item_stall is low. A pixel run is
// registered in the core, then queued and shown on result; the status
// follows the run of the same byte. A repeat run that wraps over more
// than one row (images narrower than the run) holds item_stall high
// while the column is divided by the width, one quotient bit per cycle.
// Results wait in a four-entry queue; item_stall rises once three entries
// are in use or about to be written, so a stalled receiver backs up onto
// the sender without loss.
// After reset, and after every last byte, the decoder waits for the header
// of a fresh file.
module tga_image_stream_decoder_unit
    import tsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    busy, room, take;
    push_t   push;
    result_t run_item;

    assign item_stall = busy || !room;
    assign take       = item_valid && !item_stall;

    tsd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .busy     (busy),
        .push     (push),
        .run_item (run_item)
    );

    tsd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .run_item (run_item),
        .room     (room),
        .valid    (result_valid),
        .stall    (result_stall),
        .data     (result)
    );

    a_status_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.end_of_file) |=> push.stat)
        else $error("last byte gave no status");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> item_stall)
        else $error("byte taken during division");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(take) |-> (!push.run && !push.stat))
        else $error("result pushed without a byte");

endmodule

/* rtl/core/tsd_core.sv */
// header parser, region skipper and pixel packet decoder
module tsd_core
    import tsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    output logic    busy,
    output push_t   push,
    output result_t run_item
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [7:0]  id_len_reg, id_len_next;
    logic [7:0]  cmk_reg, cmk_next;
    logic [7:0]  ikind_reg, ikind_next;
    logic [15:0] mec_reg, mec_next;
    logic [7:0]  meb_reg, meb_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  bpp_reg, bpp_next;
    logic [15:0] skip_reg, skip_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] left_reg, left_next;
    logic [7:0]  pix_reg [4];
    logic [2:0]  pidx_reg, pidx_next;
    logic [7:0]  prem_reg, prem_next;
    logic        rep_reg, rep_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic        div_busy_reg, div_busy_next;
    logic [2:0]  div_cnt_reg, div_cnt_next;
    logic [6:0]  div_num_reg, div_num_next;
    logic [6:0]  div_rem_reg, div_rem_next;
    logic [6:0]  div_q_reg, div_q_next;

    logic        b_is_rle, b_is_gray, hdr_ok, go_map, go_data, pix_wr;
    logic [7:0]  b;
    logic [7:0]  pix [4];
    logic [2:0]  nbytes;
    logic [7:0]  n;
    logic [16:0] csum, cdiff;
    logic [7:0]  trial;
    logic        data_seen;
    push_t       push_c;
    result_t     run_c;

    assign b         = item.file_byte;
    assign b_is_rle  = (ikind_reg == IMG_TRUE_RLE) || (ikind_reg == IMG_GRAY_RLE);
    assign b_is_gray = (ikind_reg == IMG_GRAY) || (ikind_reg == IMG_GRAY_RLE);
    assign nbytes    = bpp_reg[5:3];
    assign busy      = div_busy_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pix[k] = (k[1:0] == pidx_reg[1:0]) ? b : pix_reg[k];
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        id_len_next  = id_len_reg;
        cmk_next     = cmk_reg;
        ikind_next   = ikind_reg;
        mec_next     = mec_reg;
        meb_next     = meb_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        bpp_next     = bpp_reg;
        skip_next    = skip_reg;
        total_next   = total_reg;
        left_next    = left_reg;
        pidx_next    = pidx_reg;
        prem_next    = prem_reg;
        rep_next     = rep_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        div_busy_next = div_busy_reg;
        div_cnt_next = div_cnt_reg;
        div_num_next = div_num_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        go_map       = 1'b0;
        go_data      = 1'b0;
        pix_wr       = 1'b0;
        hdr_ok       = 1'b0;
        n            = 8'd1;
        csum         = '0;
        cdiff        = '0;
        trial        = '0;
        push_c       = '0;
        data_seen    = (phase_reg == PH_DATA) || (phase_reg == PH_DONE);

        run_c              = '0;
        run_c.kind         = KIND_RUN;
        run_c.start_x      = col_reg;
        run_c.start_y      = height_reg - 16'd1 - row_reg;
        if (b_is_gray)
        begin
            run_c.pixel_format = (bpp_reg == 8'd8) ? FMT_GRAY8 : FMT_GRAY16;
            run_c.red_or_gray  = pix[0];
        end
        else
        begin
            run_c.pixel_format = FMT_RGBA8;
            run_c.red_or_gray  = pix[2];
            run_c.green        = pix[1];
            run_c.blue         = pix[0];
            run_c.alpha        = (bpp_reg == 8'd32) ? pix[3] : ALPHA_OPAQUE;
        end

        // long division of the wrapped column, one quotient bit a cycle
        if (div_busy_reg)
        begin
            trial        = {div_rem_reg, div_num_reg[6]};
            div_num_next = {div_num_reg[5:0], 1'b0};
            if (trial >= width_reg[7:0])
            begin
                div_rem_next = 7'(trial - width_reg[7:0]);
                div_q_next   = {div_q_reg[5:0], 1'b1};
            end
            else
            begin
                div_rem_next = trial[6:0];
                div_q_next   = {div_q_reg[5:0], 1'b0};
            end
            div_cnt_next = div_cnt_reg + 3'd1;
            if (div_cnt_reg == 3'd6)
            begin
                div_busy_next = 1'b0;
                col_next      = {9'd0, div_rem_next};
                row_next      = row_reg + {9'd0, div_q_next};
            end
        end

        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    case (idx_reg)
                        5'd0:  id_len_next = b;
                        5'd1:  cmk_next = b;
                        5'd2:  ikind_next = b;
                        5'd5:  mec_next[7:0] = b;
                        5'd6:  mec_next[15:8] = b;
                        5'd7:  meb_next = b;
                        5'd12: width_next[7:0] = b;
                        5'd13: width_next[15:8] = b;
                        5'd14: height_next[7:0] = b;
                        5'd15: height_next[15:8] = b;
                        5'd16: bpp_next = b;
                        default: ;
                    endcase
                    if (idx_reg == HDR_DEPTH)
                    begin
                        total_next = {16'd0, width_reg} * {16'd0, height_reg};
                    end
                    if (idx_reg >= HDR_LAST)
                    begin
                        idx_next = 5'd0;
                        if ((ikind_reg == IMG_TRUE) || (ikind_reg == IMG_TRUE_RLE))
                        begin
                            hdr_ok = (bpp_reg == 8'd24) || (bpp_reg == 8'd32);
                        end
                        else if (b_is_gray)
                        begin
                            hdr_ok = (bpp_reg == 8'd8) || (bpp_reg == 8'd16);
                        end
                        if (!hdr_ok)
                        begin
                            phase_next = PH_FAIL;
                        end
                        else if (id_len_reg != 8'd0)
                        begin
                            phase_next = PH_IDSKIP;
                            skip_next  = {8'd0, id_len_reg};
                        end
                        else
                        begin
                            go_map = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
                PH_IDSKIP:
                begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_next == 16'd0)
                    begin
                        go_map = 1'b1;
                    end
                end
                PH_MAPSKIP:
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_next >= meb_reg[7:3])
                    begin
                        idx_next  = 5'd0;
                        skip_next = skip_reg - 16'd1;
                        if (skip_next == 16'd0)
                        begin
                            go_data = 1'b1;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (b_is_rle && (prem_reg == 8'd0))
                    begin
                        prem_next = (b & RUN_MASK) + 8'd1;
                        rep_next  = b[7];
                    end
                    else
                    begin
                        pix_wr    = 1'b1;
                        pidx_next = pidx_reg + 3'd1;
                        if (pidx_next >= nbytes)
                        begin
                            pidx_next = 3'd0;
                            if (b_is_rle && rep_reg)
                            begin
                                if ((left_reg[31:8] == 24'd0) && (left_reg[7:0] < prem_reg))
                                begin
                                    n = left_reg[7:0];
                                end
                                else
                                begin
                                    n = prem_reg;
                                end
                                prem_next = 8'd0;
                            end
                            else if (b_is_rle)
                            begin
                                prem_next = prem_reg - 8'd1;
                            end
                            push_c.run      = 1'b1;
                            run_c.run_count = n;
                            left_next       = left_reg - {24'd0, n};
                            if (left_next == 32'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            csum  = {1'b0, col_reg} + {9'd0, n};
                            cdiff = csum - {1'b0, width_reg};
                            if (csum < {1'b0, width_reg})
                            begin
                                col_next = csum[15:0];
                            end
                            else if (cdiff < {1'b0, width_reg})
                            begin
                                col_next = cdiff[15:0];
                                row_next = row_reg + 16'd1;
                            end
                            else
                            begin
                                // several rows wrapped: narrow image, divide
                                row_next      = row_reg + 16'd1;
                                div_busy_next = 1'b1;
                                div_cnt_next  = 3'd0;
                                div_num_next  = cdiff[6:0];
                                div_rem_next  = 7'd0;
                                div_q_next    = 7'd0;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (go_map)
            begin
                if ((cmk_reg == CMAP_PRESENT) && (mec_reg != 16'd0)
                    && (meb_reg[7:3] != 5'd0))
                begin
                    phase_next = PH_MAPSKIP;
                    skip_next  = mec_reg;
                    idx_next   = 5'd0;
                end
                else
                begin
                    go_data = 1'b1;
                end
            end
            if (go_data)
            begin
                phase_next = (total_reg == 32'd0) ? PH_DONE : PH_DATA;
                left_next  = total_reg;
                pidx_next  = 3'd0;
                prem_next  = 8'd0;
                rep_next   = 1'b0;
            end

            if (item.end_of_file)
            begin
                push_c.stat    = 1'b1;
                push_c.stat_ok = (phase_next == PH_DONE)
                    || ((phase_next == PH_DATA) && data_seen && b_is_rle);
                phase_next    = PH_HEADER;
                idx_next      = '0;
                id_len_next   = '0;
                cmk_next      = '0;
                ikind_next    = '0;
                mec_next      = '0;
                meb_next      = '0;
                width_next    = '0;
                height_next   = '0;
                bpp_next      = '0;
                skip_next     = '0;
                total_next    = '0;
                left_next     = '0;
                pidx_next     = '0;
                prem_next     = '0;
                rep_next      = 1'b0;
                col_next      = '0;
                row_next      = '0;
                div_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            id_len_reg   <= '0;
            cmk_reg      <= '0;
            ikind_reg    <= '0;
            mec_reg      <= '0;
            meb_reg      <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            bpp_reg      <= '0;
            skip_reg     <= '0;
            total_reg    <= '0;
            left_reg     <= '0;
            pidx_reg     <= '0;
            prem_reg     <= '0;
            rep_reg      <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            push         <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            id_len_reg   <= id_len_next;
            cmk_reg      <= cmk_next;
            ikind_reg    <= ikind_next;
            mec_reg      <= mec_next;
            meb_reg      <= meb_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            bpp_reg      <= bpp_next;
            skip_reg     <= skip_next;
            total_reg    <= total_next;
            left_reg     <= left_next;
            pidx_reg     <= pidx_next;
            prem_reg     <= prem_next;
            rep_reg      <= rep_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
            push         <= push_c;
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        run_item    <= run_c;
        if (pix_wr)
        begin
            pix_reg[pidx_reg[1:0]] <= b;
        end
    end

endmodule

/* rtl/core/tsd_outq.sv */
// four-entry result queue taking up to two results a cycle
module tsd_outq
    import tsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  result_t run_item,
    output logic    room,
    output logic    valid,
    input  logic    stall,
    output result_t data
);

    result_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QUEUE_PW:0]   cnt_reg, cnt_next;
    logic                pop;
    result_t             stat_item;

    always_comb
    begin
        stat_item      = '0;
        stat_item.kind = push.stat_ok ? KIND_OK : KIND_FAIL;
    end

    assign valid = (cnt_reg != '0);
    assign data  = mem[rd_reg];
    assign pop   = valid && !stall;
    // entries already held plus those being written this cycle
    assign room  = ((cnt_reg + (QUEUE_PW+1)'(push.run) + (QUEUE_PW+1)'(push.stat))
                    <= (QUEUE_PW+1)'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_next  = wr_reg + QUEUE_PW'(push.run) + QUEUE_PW'(push.stat);
        rd_next  = rd_reg + QUEUE_PW'(pop);
        cnt_next = cnt_reg + (QUEUE_PW+1)'(push.run) + (QUEUE_PW+1)'(push.stat)
                   - (QUEUE_PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.run)
        begin
            mem[wr_reg] <= run_item;
        end
        if (push.stat)
        begin
            mem[wr_reg + QUEUE_PW'(push.run)] <= stat_item;
        end
    end

endmodule
